[rtl/osmt_pkg.sv]
// shared types and constants for the ordered set membership table
package osmt_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int ITEM_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_ERASE    = 2'd1,
      CMD_CONTAINS = 2'd2,
      CMD_GET      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MATCH = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] key_value;
      logic [5:0]  position;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [31:0] read_value;
      logic [6:0]  entry_count;
      logic        full_reject;
   } rsp_type;

   // broadcast controls from the sequencer to every slot
   typedef struct packed {
      logic evaluate;   // latch a fresh hit flag
      logic by_pos;     // compare slot index instead of stored value
      logic pos_ok;     // requested index lies below the count
      logic push;       // shift toward the older end, slot 0 takes the key
      logic pull;       // close the gap at and after the hit
   } cell_ctl_type;

endpackage

[rtl/ordered_set_membership_table_core.sv]
// top level: ordered set of distinct values held in a chain of slots
//
//   channel  direction  ports                          payload
//   req      in         req_valid req_stall            req_type (command, key_value, position)
//   rsp      out        rsp_valid rsp_stall            rsp_type (success, read_value,
//                                                      entry_count, full_reject)
//
// each item first broadcasts the command and latches a hit flag in every
// slot, then resolves the hit chain and shifts the slots
// a new item is taken in the resolve cycle, while the last item still resolves
// reset clears the count, the sequencer and the hit flags; slot values stay
// undefined until written and are never read above the count
// a stalled result holds the resolve cycle, and with it the input side
module ordered_set_membership_table_core import osmt_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CW = $clog2(CAPACITY + 1);   // count width
   localparam int PW = (CW > 6) ? CW : 6;      // width to compare index and count

   // sequencer and broadcast registers
   state_type             state_ff, state_in;
   logic [1:0]            cmd_ff;
   logic [ITEM_WIDTH-1:0] key_ff;
   logic [5:0]            pos_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  out_free;
   logic                  apply_go;
   logic [63:0]           key_wide;
   logic [PW-1:0]         pos_wide;
   logic                  pos_ok;
   logic                  full;
   logic                  any_hit;
   logic                  ok;
   logic                  reject;
   cell_ctl_type          ctl;

   // slot chain wiring
   logic [ITEM_WIDTH-1:0] data_w   [CAPACITY];
   logic [ITEM_WIDTH-1:0] masked_w [CAPACITY];
   logic [CAPACITY-1:0]   hit_w;
   logic [CAPACITY-1:0]   prefix_w;
   logic [ITEM_WIDTH-1:0] read_or;
   logic [63:0]           read_wide;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign apply_go  = (state_ff == ST_APPLY) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || apply_go);
   assign accept    = req_valid && !req_stall;

   // keys wider than the stored item lose their upper bits
   assign key_wide = 64'(req_payload.key_value);

   // get index range check, done while the count is steady
   assign pos_wide = PW'(pos_ff);
   assign pos_ok   = pos_wide < PW'(count_ff);
   assign full     = count_ff == CW'(CAPACITY);
   assign any_hit  = prefix_w[CAPACITY-1];

   // outcome of the item in the resolve cycle
   always_comb begin
      ok     = 1'b0;
      reject = 1'b0;
      case (cmd_ff)
         CMD_INSERT: begin
            ok     = !any_hit && !full;
            reject = !any_hit && full;
         end
         default: begin
            ok = any_hit;
         end
      endcase
   end

   always_comb begin
      ctl.evaluate = state_ff == ST_MATCH;
      ctl.by_pos   = cmd_ff == CMD_GET;
      ctl.pos_ok   = pos_ok;
      ctl.push     = apply_go && (cmd_ff == CMD_INSERT) && ok;
      ctl.pull     = apply_go && (cmd_ff == CMD_ERASE) && ok;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
      logic [ITEM_WIDTH-1:0] newer;
      logic [ITEM_WIDTH-1:0] older;
      logic                  prev_hit;

      if (i == 0) begin : g_head
         assign newer    = key_ff;
         assign prev_hit = 1'b0;
      end else begin : g_body
         assign newer    = data_w[i-1];
         assign prev_hit = prefix_w[i-1];
      end

      // the oldest slot pulls nothing meaningful: it drops out of the count
      if (i == CAPACITY - 1) begin : g_tail
         assign older = key_ff;
      end else begin : g_mid
         assign older = data_w[i+1];
      end

      osmt_cell #(
         .ITEM_WIDTH (ITEM_WIDTH),
         .CW         (CW),
         .INDEX      (i)
      ) u_slot (
         .clock          (clock),
         .reset          (reset),
         .ctl_in         (ctl),
         .count_in       (count_ff),
         .pos_in         (pos_wide[CW-1:0]),
         .key_in         (key_ff),
         .newer_data_in  (newer),
         .older_data_in  (older),
         .prefix_hit_in  (prev_hit),
         .prefix_hit_out (prefix_w[i]),
         .hit_out        (hit_w[i]),
         .data_out       (data_w[i]),
         .masked_out     (masked_w[i])
      );
   end

   // at most one slot hits, so an or of the masked values selects it
   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | masked_w[i];
      end
   end
   assign read_wide = 64'(read_or);

   // count after the item
   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pull) begin
         count_in = count_ff - CW'(1);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) begin
               state_in = accept ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_in             = rsp_ff;
      rsp_in.success     = ok;
      rsp_in.read_value  = ((cmd_ff == CMD_GET) && ok) ? read_wide[31:0] : 32'd0;
      rsp_in.entry_count = 7'(count_in);
      rsp_in.full_reject = reject;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_payload.command;
         key_ff <= key_wide[ITEM_WIDTH-1:0];
         pos_ff <= req_payload.position;
      end
      if (apply_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // stored values are distinct and index matches are unique
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> $onehot0(hit_w))
      else $error("more than one slot hit");

   // count moves by at most one per item
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ((count_ff == $past(count_ff) + CW'(1)) || (count_ff == $past(count_ff) - CW'(1))))
      else $error("count jumped");

   // a new result only comes out of the resolve cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_APPLY))
      else $error("result without resolve");

   // a refused insert never reports success
   a_reject_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.success && rsp_ff.full_reject))
      else $error("success and reject together");

endmodule

[rtl/osmt_cell.sv]
// one slot of the table: stored value, hit flag and neighbor shift
module osmt_cell import osmt_pkg::*; #(
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
   parameter int CW         = 7,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl_in,
   input  logic [CW-1:0]         count_in,
   input  logic [CW-1:0]         pos_in,
   input  logic [ITEM_WIDTH-1:0] key_in,
   input  logic [ITEM_WIDTH-1:0] newer_data_in,
   input  logic [ITEM_WIDTH-1:0] older_data_in,
   input  logic                  prefix_hit_in,
   output logic                  prefix_hit_out,
   output logic                  hit_out,
   output logic [ITEM_WIDTH-1:0] data_out,
   output logic [ITEM_WIDTH-1:0] masked_out
);

   logic [ITEM_WIDTH-1:0] data_ff, data_in;
   logic                  hit_ff, hit_in;
   logic                  occupied;

   assign occupied = CW'(INDEX) < count_in;

   always_comb begin
      hit_in = hit_ff;
      if (ctl_in.evaluate) begin
         if (ctl_in.by_pos) begin
            hit_in = occupied && ctl_in.pos_ok && (CW'(INDEX) == pos_in);
         end else begin
            hit_in = occupied && (data_ff == key_in);
         end
      end
   end

   always_comb begin
      data_in = data_ff;
      if (ctl_in.push) begin
         data_in = newer_data_in;
      end else if (ctl_in.pull && prefix_hit_out) begin
         data_in = older_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign prefix_hit_out = prefix_hit_in | hit_ff;
   assign hit_out        = hit_ff;
   assign data_out       = data_ff;
   assign masked_out     = data_ff & {ITEM_WIDTH{hit_ff}};

endmodule

[dv/ordered_set_membership_table_core_test.sv]
// self-checking bench for the ordered set membership table: directed and random commands
`timescale 1ns / 100ps

module ordered_set_membership_table_core_test;
   import osmt_pkg::*;

   localparam int POOL_SIZE    = 96;     // reused keys, more than the table holds
   localparam int HOLD_AT      = 150;    // items sent before the long receiver hold
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 3000;   // cycles with no item moving on either side

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   ordered_set_membership_table_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // commands waiting to go out, results still owed by the block
   req_type     command_queue[$];
   rsp_type     answers_due[$];
   // mirror of the table, index 0 is the newest value
   logic [31:0] mirror_entries[$];
   logic [31:0] key_pool[POOL_SIZE];

   int error_count   = 0;
   int sent_count    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   bit hold_taken    = 1'b0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // run one command on the mirror and return the answer the block owes
   function automatic rsp_type apply_to_mirror(req_type item);
      rsp_type answer;
      int      hit;
      int      k;
      answer = '0;
      hit = -1;
      for (k = 0; k < mirror_entries.size(); k++) begin
         if (hit < 0 && mirror_entries[k] == item.key_value)
            hit = k;
      end
      case (cmd_type'(item.command))
         CMD_INSERT: begin
            if (hit >= 0)
               answer.success = 1'b0;   // already present, nothing moves
            else if (mirror_entries.size() >= CAPACITY_DEF)
               answer.full_reject = 1'b1;
            else begin
               mirror_entries.push_front(item.key_value);
               answer.success = 1'b1;
            end
         end
         CMD_ERASE: begin
            if (hit >= 0) begin
               mirror_entries.delete(hit);   // older values close the gap
               answer.success = 1'b1;
            end
         end
         CMD_CONTAINS: begin
            answer.success = (hit >= 0);
         end
         default: begin
            if (item.position < mirror_entries.size()) begin
               answer.read_value = mirror_entries[item.position];
               answer.success    = 1'b1;
            end
         end
      endcase
      answer.entry_count = 7'(mirror_entries.size());
      return answer;
   endfunction

   // sender: predict at acceptance, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            answers_due.push_back(apply_to_mirror(req_payload));
            sent_count <= sent_count + 1;
         end
         // a stalled item stays put; otherwise the slot is free
         if (!req_valid || !req_stall) begin
            if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= command_queue.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_taken && sent_count >= HOLD_AT) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // result checker, field by field against the oldest answer owed
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_payload.entry_count), '0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_payload.success !== want.success)
               report_mismatch("success", 32'(rsp_payload.success), 32'(want.success));
            if (rsp_payload.read_value !== want.read_value)
               report_mismatch("read_value", rsp_payload.read_value, want.read_value);
            if (rsp_payload.entry_count !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_payload.entry_count),
                               32'(want.entry_count));
            if (rsp_payload.full_reject !== want.full_reject)
               report_mismatch("full_reject", 32'(rsp_payload.full_reject),
                               32'(want.full_reject));
         end
      end
   end

   // watchdog: ends the run when nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no item moved in %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic queue_item(cmd_type cmd, logic [31:0] key, logic [5:0] pos);
      req_type item;
      item.command   = cmd;
      item.key_value = key;
      item.position  = pos;
      command_queue.push_back(item);
   endtask

   // mode 0 leans to inserts, mode 1 to erases, mode 2 is even
   function automatic req_type random_item(int mode);
      req_type item;
      int      roll;
      int      ins_w;
      int      era_w;
      int      con_w;
      case (mode)
         0: begin ins_w = 65; era_w = 10; con_w = 15; end
         1: begin ins_w = 10; era_w = 60; con_w = 15; end
         default: begin ins_w = 25; era_w = 25; con_w = 25; end
      endcase
      roll = $urandom_range(99);
      if (roll < ins_w)
         item.command = CMD_INSERT;
      else if (roll < ins_w + era_w)
         item.command = CMD_ERASE;
      else if (roll < ins_w + era_w + con_w)
         item.command = CMD_CONTAINS;
      else
         item.command = CMD_GET;
      // mostly pooled keys so inserts collide and erases hit
      if ($urandom_range(99) < 85)
         item.key_value = key_pool[$urandom_range(POOL_SIZE - 1)];
      else
         item.key_value = $urandom();
      item.position = 6'($urandom_range(63));
      return item;
   endfunction

   task automatic wait_drained();
      while (command_queue.size() != 0 || req_valid || answers_due.size() != 0)
         @(posedge clock);
   endtask

   // one idling setting: a fill past capacity, a shuffled drain, then bursts
   task automatic run_phase(int send_pct, int stall_pct, int burst_items);
      logic [31:0] fresh[$];
      int          n;
      int          pick;
      int          mode;
      int          len;
      int          k;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < CAPACITY_DEF + 4; n++) begin
         fresh.push_back($urandom());
         queue_item(CMD_INSERT, fresh[n], 6'($urandom_range(63)));
      end
      // table is full here: probe both ends and a repeat
      queue_item(CMD_INSERT, fresh[0], '0);
      queue_item(CMD_GET, $urandom(), 6'd0);
      queue_item(CMD_GET, $urandom(), 6'd63);
      queue_item(CMD_CONTAINS, fresh[fresh.size() - 1], '0);
      while (fresh.size() != 0) begin
         pick = $urandom_range(fresh.size() - 1);
         queue_item(CMD_ERASE, fresh[pick], 6'($urandom_range(63)));
         fresh.delete(pick);
         if ($urandom_range(3) == 0)
            command_queue.push_back(random_item(2));
      end
      n = 0;
      while (n < burst_items) begin
         mode = $urandom_range(2);
         len  = $urandom_range(20, 80);
         for (k = 0; k < len; k++)
            command_queue.push_back(random_item(mode));
         n += len;
      end
      wait_drained();
   endtask

   initial begin
      int k;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (k = 2; k < POOL_SIZE; k++)
         key_pool[k] = $urandom();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extreme keys, duplicates, middle erase, index edges
      queue_item(CMD_GET,      32'h0000_0000, 6'd0);
      queue_item(CMD_CONTAINS, 32'h0000_0000, 6'd63);
      queue_item(CMD_ERASE,    32'hFFFF_FFFF, 6'd0);
      queue_item(CMD_INSERT,   32'h0000_0000, 6'd0);
      queue_item(CMD_INSERT,   32'hFFFF_FFFF, 6'd63);
      queue_item(CMD_INSERT,   32'h0000_0000, 6'd0);
      queue_item(CMD_CONTAINS, 32'hFFFF_FFFF, 6'd0);
      queue_item(CMD_CONTAINS, 32'h1234_5678, 6'd0);
      queue_item(CMD_GET,      32'hFFFF_FFFF, 6'd0);
      queue_item(CMD_GET,      32'h0000_0000, 6'd1);
      queue_item(CMD_GET,      32'h0000_0000, 6'd2);
      queue_item(CMD_GET,      32'hFFFF_FFFF, 6'd63);
      queue_item(CMD_INSERT,   32'h0000_0001, 6'd0);
      queue_item(CMD_INSERT,   32'h0000_0002, 6'd0);
      queue_item(CMD_INSERT,   32'h0000_0003, 6'd0);
      queue_item(CMD_ERASE,    32'h0000_0002, 6'd0);
      queue_item(CMD_GET,      32'h0000_0000, 6'd1);
      queue_item(CMD_GET,      32'h0000_0000, 6'd2);
      queue_item(CMD_ERASE,    32'h0000_0000, 6'd0);
      queue_item(CMD_ERASE,    32'h0000_0003, 6'd0);
      queue_item(CMD_ERASE,    32'h0000_0003, 6'd0);
      queue_item(CMD_GET,      32'hAAAA_5555, 6'd1);
      queue_item(CMD_GET,      32'h5555_AAAA, 6'd2);
      wait_drained();

      run_phase(0, 0, 150);     // long receiver hold lands in here
      run_phase(68, 0, 150);
      run_phase(0, 68, 150);
      run_phase(12, 12, 150);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (answers_due.size() != 0)
         report_mismatch("results never returned", 32'(answers_due.size()), '0);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/osmt_pkg.sv
rtl/osmt_cell.sv
rtl/ordered_set_membership_table_core.sv
dv/ordered_set_membership_table_core_test.sv
